// File: rtl/chs_pkg.sv
// chs_pkg: shared types, widths, codes and states of the cubic hermite spline table
// used by chs_mul, chs_div, the top level and the checker, depends on nothing
package chs_pkg;

  localparam int unsigned MAX_KNOTS = 32;
  localparam int unsigned IDX_W     = $clog2(MAX_KNOTS);
  localparam int unsigned CNT_W     = $clog2(MAX_KNOTS + 1);

  localparam int unsigned TIME_W = 32;
  localparam int unsigned STEP_W = 24;
  localparam int unsigned U_W    = 25;
  localparam int unsigned BAS_W  = 26;
  localparam int unsigned SM_W   = 49;
  localparam int unsigned ACC_W  = 60;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd655;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DOMAIN = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_EVAL   = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef struct packed {
    logic [31:0]        tm;
    logic signed [31:0] val;
    logic signed [31:0] slp;
  } knot_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_DEC,
    S_ADD_SHRD,
    S_ADD_SHWR,
    S_ADD_PUT,
    S_GET_LAST,
    S_GET_FIRST,
    S_DOMAIN,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DIV_GO,
    S_DIV_WT,
    S_PRE,
    S_T_HI,
    S_T_LO,
    S_T_ACC,
    S_FIN,
    S_OUT
  } state_e;

endpackage

// File: rtl/chs_ram.sv
// chs_ram: generic single write port, single read port ram with registered read
// no dependencies
module chs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/chs_mul.sv
// chs_mul: shared unsigned multiplier with registered product
// depends on chs_pkg for operand widths
module chs_mul (
  input  logic                         clk_i,
  input  logic [chs_pkg::MUL_W-1:0]    a_i,
  input  logic [chs_pkg::MUL_W-1:0]    b_i,
  output logic [chs_pkg::PROD_W-1:0]   p_o
);

  logic [chs_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: rtl/chs_div.sv
// chs_div: restoring divider, one quotient bit per cycle, for the normalized position
// computes round((num << 24) / den), depends on chs_pkg
module chs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [31:0]                  num_i,
  input  logic [31:0]                  den_i,
  output logic                         done_o,
  output logic [chs_pkg::U_W-1:0]      quo_o
);

  logic [56:0]                 nfull;
  logic [31:0]                 rem_q, rem_d;
  logic [chs_pkg::U_W-1:0]     nbit_q, nbit_d;
  logic [chs_pkg::U_W-1:0]     quo_q, quo_d;
  logic [31:0]                 den_q, den_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [32:0]                 trial;
  logic                        fits;

  assign nfull = {1'b0, num_i, 24'b0} + {26'b0, den_i[31:1]};
  assign trial = {rem_q, nbit_q[chs_pkg::U_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    nbit_d = nbit_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = nfull[56:25];
      nbit_d = nfull[24:0];
      den_d  = den_i;
      cnt_d  = 5'(chs_pkg::U_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      nbit_d = {nbit_q[chs_pkg::U_W-2:0], 1'b0};
      quo_d  = {quo_q[chs_pkg::U_W-2:0], fits};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    nbit_q <= nbit_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/cubic_hermite_spline_table_top.sv
// cubic_hermite_spline_table_top: sorted knot table with cubic hermite evaluation
// depends on chs_pkg, chs_ram, chs_div and chs_mul
//
// One request beat is handled at a time; in_stall_o stays high from acceptance until the
// result beat is taken. The knot table sits in a ram with one write port, one read port
// and registered read, so every knot visited takes a read state and a second state that
// uses the data. An add walks the table to the position of its time, shifts the later
// knots up one place and writes the new knot, or overwrites a knot of the same time; an
// evaluate or sample reads the last and first knot, scans for its segment, runs the
// one-bit-per-cycle divider for the normalized position and then does its arithmetic on
// the one shared multiplier. A clear answers on the next cycle. The table needs no
// clearing after reset.
module cubic_hermite_spline_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] point_x_i,
  input  logic signed [31:0] knot_value_i,
  input  logic signed [31:0] knot_slope_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [31:0] result_time_o,
  output logic [1:0]  status_o,
  output logic        last_sample_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_sample_step_i
);

  localparam int unsigned IW = chs_pkg::IDX_W;
  localparam int unsigned CW = chs_pkg::CNT_W;

  chs_pkg::state_e state_q, state_d;
  chs_pkg::req_e   req_q, req_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   j_q, j_d;
  logic [31:0]     st_q, st_d;
  logic            active_q, active_d;
  logic [23:0]     step_q;

  logic [31:0]              x_q, x_d;
  logic signed [31:0]       kv_q, kv_d, ks_q, ks_d;
  logic [31:0]              tend_q, tend_d, q_q, q_d, h_q, h_d, d_q, d_d;
  chs_pkg::knot_t           a_q, a_d, b_q, b_d;
  logic [chs_pkg::U_W-1:0]  u_q, u_d, u2_q, u2_d, u3_q, u3_d;
  logic signed [chs_pkg::SM_W-1:0]  sm0_q, sm0_d, sm1_q, sm1_d;
  logic signed [chs_pkg::BAS_W-1:0] bas_q [4];
  logic signed [chs_pkg::BAS_W-1:0] bas_d [4];
  logic [1:0]               tk_q, tk_d;
  logic [2:0]               ms_q, ms_d;
  logic [57:0]              p1_q, p1_d;
  logic signed [chs_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [31:0]       val_q, val_d;
  logic [31:0]              tim_q, tim_d;
  logic [1:0]               stat_q, stat_d;
  logic                     last_q, last_d;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  chs_pkg::knot_t       ram_wdata, rd;
  logic                 div_start, div_done;
  logic [chs_pkg::U_W-1:0]    div_quo;
  logic [chs_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [chs_pkg::PROD_W-1:0] mul_p;

  logic [CW-1:0]        jm1, cm1, idx1;
  logic [31:0]          st_sel, st_next, hseg;
  logic [32:0]          st_sum;
  logic [23:0]          step_eff;
  logic [49:0]          rnd_sum;
  logic [63:0]          sc_sum;
  logic [47:0]          sc_mag;
  logic [31:0]          a_smag, b_smag;
  logic signed [27:0]   eu, eu2, eu3;
  logic signed [chs_pkg::SM_W-1:0]  opnd;
  logic [chs_pkg::SM_W-1:0]         omag;
  logic signed [chs_pkg::BAS_W-1:0] bsel;
  logic [chs_pkg::BAS_W-1:0]        bmag;
  logic                 tneg;
  logic [57:0]          tsum;
  logic [chs_pkg::ACC_W-1:0] amag, asum;
  logic [51:0]          rmag;
  logic                 aneg;

  chs_ram #(
    .WIDTH ($bits(chs_pkg::knot_t)),
    .DEPTH (chs_pkg::MAX_KNOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  chs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (d_q),
    .den_i   (h_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  chs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign jm1  = j_q - CW'(1);
  assign cm1  = count_q - CW'(1);
  assign idx1 = idx_q + CW'(1);

  assign step_eff = (step_q == 24'd0) ? 24'd1 : step_q;
  assign st_sel   = active_q ? st_q : rd.tm;
  assign st_sum   = {1'b0, st_sel} + {9'b0, step_eff};
  assign st_next  = st_sum[32] ? 32'hFFFF_FFFF : st_sum[31:0];
  assign hseg     = (rd.tm == a_q.tm) ? 32'd1 : 32'(rd.tm - a_q.tm);

  assign rnd_sum = mul_p[49:0] + 50'h80_0000;
  assign sc_sum  = mul_p[63:0] + 64'h8000;
  assign sc_mag  = sc_sum[63:16];
  assign a_smag  = a_q.slp[31] ? 32'(-a_q.slp) : 32'(a_q.slp);
  assign b_smag  = b_q.slp[31] ? 32'(-b_q.slp) : 32'(b_q.slp);

  assign eu  = 28'(signed'({1'b0, u_q}));
  assign eu2 = 28'(signed'({1'b0, u2_q}));
  assign eu3 = 28'(signed'({1'b0, u3_q}));

  always_comb begin
    case (tk_q)
      2'd0:    opnd = chs_pkg::SM_W'(a_q.val);
      2'd1:    opnd = sm0_q;
      2'd2:    opnd = chs_pkg::SM_W'(b_q.val);
      default: opnd = sm1_q;
    endcase
  end

  assign omag = opnd[chs_pkg::SM_W-1] ? chs_pkg::SM_W'(-opnd) : chs_pkg::SM_W'(opnd);
  assign bsel = bas_q[tk_q];
  assign bmag = bsel[chs_pkg::BAS_W-1] ? chs_pkg::BAS_W'(-bsel) : chs_pkg::BAS_W'(bsel);
  assign tneg = bsel[chs_pkg::BAS_W-1] ^ opnd[chs_pkg::SM_W-1];
  assign tsum = p1_q + {16'b0, mul_p[57:16]};

  assign aneg = acc_q[chs_pkg::ACC_W-1];
  assign amag = aneg ? chs_pkg::ACC_W'(-acc_q) : chs_pkg::ACC_W'(acc_q);
  assign asum = amag + chs_pkg::ACC_W'(128);
  assign rmag = asum[59:8];

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    count_d  = count_q;
    idx_d    = idx_q;
    j_d      = j_q;
    st_d     = st_q;
    active_d = active_q;
    x_d      = x_q;
    kv_d     = kv_q;
    ks_d     = ks_q;
    tend_d   = tend_q;
    q_d      = q_q;
    h_d      = h_q;
    d_d      = d_q;
    a_d      = a_q;
    b_d      = b_q;
    u_d      = u_q;
    u2_d     = u2_q;
    u3_d     = u3_q;
    sm0_d    = sm0_q;
    sm1_d    = sm1_q;
    bas_d    = bas_q;
    tk_d     = tk_q;
    ms_d     = ms_q;
    p1_d     = p1_q;
    acc_d    = acc_q;
    val_d    = val_q;
    tim_d    = tim_q;
    stat_d   = stat_q;
    last_d   = last_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IW-1:0];
    ram_wdata = rd;
    ram_raddr = idx_q[IW-1:0];
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;

    unique case (state_q)
      chs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d  = chs_pkg::req_e'(req_type_i);
          x_d    = point_x_i;
          kv_d   = knot_value_i;
          ks_d   = knot_slope_i;
          val_d  = '0;
          tim_d  = '0;
          stat_d = chs_pkg::ST_OK;
          last_d = 1'b0;
          idx_d  = '0;
          unique case (chs_pkg::req_e'(req_type_i))
            chs_pkg::REQ_ADD: begin
              active_d = 1'b0;
              tim_d    = point_x_i;
              state_d  = (count_q == '0) ? chs_pkg::S_ADD_DEC : chs_pkg::S_ADD_RD;
            end
            chs_pkg::REQ_EVAL: begin
              tim_d = point_x_i;
              if (count_q < CW'(2)) begin
                stat_d  = chs_pkg::ST_DOMAIN;
                state_d = chs_pkg::S_OUT;
              end else begin
                state_d = chs_pkg::S_GET_LAST;
              end
            end
            chs_pkg::REQ_SAMPLE: begin
              if (count_q < CW'(2)) begin
                stat_d  = chs_pkg::ST_DOMAIN;
                state_d = chs_pkg::S_OUT;
              end else begin
                state_d = chs_pkg::S_GET_LAST;
              end
            end
            default: begin
              count_d  = '0;
              active_d = 1'b0;
              state_d  = chs_pkg::S_OUT;
            end
          endcase
        end
      end
      chs_pkg::S_ADD_RD: begin
        ram_raddr = idx_q[IW-1:0];
        state_d   = chs_pkg::S_ADD_CHK;
      end
      chs_pkg::S_ADD_CHK: begin
        if (rd.tm < x_q) begin
          idx_d   = idx1;
          state_d = (idx1 == count_q) ? chs_pkg::S_ADD_DEC : chs_pkg::S_ADD_RD;
        end else if (rd.tm == x_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[IW-1:0];
          ram_wdata = '{tm: x_q, val: kv_q, slp: ks_q};
          state_d   = chs_pkg::S_OUT;
        end else begin
          state_d = chs_pkg::S_ADD_DEC;
        end
      end
      chs_pkg::S_ADD_DEC: begin
        if (count_q == CW'(chs_pkg::MAX_KNOTS)) begin
          stat_d  = chs_pkg::ST_FULL;
          state_d = chs_pkg::S_OUT;
        end else begin
          j_d     = count_q;
          state_d = (count_q == idx_q) ? chs_pkg::S_ADD_PUT : chs_pkg::S_ADD_SHRD;
        end
      end
      chs_pkg::S_ADD_SHRD: begin
        ram_raddr = jm1[IW-1:0];
        state_d   = chs_pkg::S_ADD_SHWR;
      end
      chs_pkg::S_ADD_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IW-1:0];
        ram_wdata = rd;
        j_d       = jm1;
        state_d   = (jm1 == idx_q) ? chs_pkg::S_ADD_PUT : chs_pkg::S_ADD_SHRD;
      end
      chs_pkg::S_ADD_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[IW-1:0];
        ram_wdata = '{tm: x_q, val: kv_q, slp: ks_q};
        count_d   = count_q + CW'(1);
        state_d   = chs_pkg::S_OUT;
      end
      chs_pkg::S_GET_LAST: begin
        ram_raddr = cm1[IW-1:0];
        state_d   = chs_pkg::S_GET_FIRST;
      end
      chs_pkg::S_GET_FIRST: begin
        tend_d    = rd.tm;
        ram_raddr = '0;
        state_d   = chs_pkg::S_DOMAIN;
      end
      chs_pkg::S_DOMAIN: begin
        a_d = rd;
        if (req_q == chs_pkg::REQ_EVAL) begin
          if (x_q < rd.tm || x_q > tend_q) begin
            stat_d  = chs_pkg::ST_DOMAIN;
            state_d = chs_pkg::S_OUT;
          end else begin
            q_d     = x_q;
            state_d = chs_pkg::S_SCAN_RD;
          end
        end else begin
          if (st_sel < tend_q) begin
            q_d      = st_sel;
            tim_d    = st_sel;
            st_d     = st_next;
            active_d = 1'b1;
          end else begin
            q_d      = tend_q;
            tim_d    = tend_q;
            last_d   = 1'b1;
            active_d = 1'b0;
          end
          state_d = chs_pkg::S_SCAN_RD;
        end
      end
      chs_pkg::S_SCAN_RD: begin
        ram_raddr = idx1[IW-1:0];
        state_d   = chs_pkg::S_SCAN_CHK;
      end
      chs_pkg::S_SCAN_CHK: begin
        b_d = rd;
        if (({1'b0, idx_q} + (CW + 1)'(2) >= {1'b0, count_q}) ||
            (q_q >= a_q.tm && q_q <= rd.tm)) begin
          h_d     = hseg;
          d_d     = q_q - a_q.tm;
          state_d = chs_pkg::S_DIV_GO;
        end else begin
          a_d     = rd;
          idx_d   = idx1;
          state_d = chs_pkg::S_SCAN_RD;
        end
      end
      chs_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = chs_pkg::S_DIV_WT;
      end
      chs_pkg::S_DIV_WT: begin
        if (div_done) begin
          u_d     = div_quo;
          ms_d    = '0;
          state_d = chs_pkg::S_PRE;
        end
      end
      chs_pkg::S_PRE: begin
        ms_d = ms_q + 3'd1;
        case (ms_q)
          3'd0: begin
            mul_a = {8'b0, u_q};
            mul_b = {8'b0, u_q};
          end
          3'd1: begin
            u2_d  = rnd_sum[48:24];
            mul_a = {1'b0, h_q};
            mul_b = {1'b0, a_smag};
          end
          3'd2: begin
            sm0_d = a_q.slp[31] ? -chs_pkg::SM_W'({1'b0, sc_mag})
                                : chs_pkg::SM_W'({1'b0, sc_mag});
            mul_a = {8'b0, u2_q};
            mul_b = {8'b0, u_q};
          end
          3'd3: begin
            u3_d  = rnd_sum[48:24];
            mul_a = {1'b0, h_q};
            mul_b = {1'b0, b_smag};
          end
          default: begin
            sm1_d = b_q.slp[31] ? -chs_pkg::SM_W'({1'b0, sc_mag})
                                : chs_pkg::SM_W'({1'b0, sc_mag});
            bas_d[0] = chs_pkg::BAS_W'(28'sd2 * eu3 - 28'sd3 * eu2 + 28'sh100_0000);
            bas_d[1] = chs_pkg::BAS_W'(eu3 - 28'sd2 * eu2 + eu);
            bas_d[2] = chs_pkg::BAS_W'(28'sd3 * eu2 - 28'sd2 * eu3);
            bas_d[3] = chs_pkg::BAS_W'(eu3 - eu2);
            acc_d    = '0;
            tk_d     = '0;
            state_d  = chs_pkg::S_T_HI;
          end
        endcase
      end
      chs_pkg::S_T_HI: begin
        mul_a   = {7'b0, bmag};
        mul_b   = {1'b0, omag[47:16]};
        state_d = chs_pkg::S_T_LO;
      end
      chs_pkg::S_T_LO: begin
        p1_d    = mul_p[57:0];
        mul_a   = {7'b0, bmag};
        mul_b   = {17'b0, omag[15:0]};
        state_d = chs_pkg::S_T_ACC;
      end
      chs_pkg::S_T_ACC: begin
        acc_d   = tneg ? acc_q - chs_pkg::ACC_W'(tsum) : acc_q + chs_pkg::ACC_W'(tsum);
        tk_d    = tk_q + 2'd1;
        state_d = (tk_q == 2'd3) ? chs_pkg::S_FIN : chs_pkg::S_T_HI;
      end
      chs_pkg::S_FIN: begin
        if (!aneg && rmag > 52'h7FFF_FFFF) begin
          val_d  = 32'sh7FFF_FFFF;
          stat_d = chs_pkg::ST_SAT;
        end else if (aneg && rmag > 52'h8000_0000) begin
          val_d  = 32'sh8000_0000;
          stat_d = chs_pkg::ST_SAT;
        end else begin
          val_d  = aneg ? 32'(-rmag[31:0]) : 32'(rmag[31:0]);
          stat_d = chs_pkg::ST_OK;
        end
        state_d = chs_pkg::S_OUT;
      end
      chs_pkg::S_OUT: begin
        if (!out_stall_i) begin
          state_d = chs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = chs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= chs_pkg::S_IDLE;
      count_q  <= '0;
      st_q     <= '0;
      active_q <= 1'b0;
      step_q   <= chs_pkg::STEP_RESET;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      st_q     <= st_d;
      active_q <= active_d;
      if (cfg_valid_i) begin
        step_q <= cfg_sample_step_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    j_q    <= j_d;
    x_q    <= x_d;
    kv_q   <= kv_d;
    ks_q   <= ks_d;
    tend_q <= tend_d;
    q_q    <= q_d;
    h_q    <= h_d;
    d_q    <= d_d;
    a_q    <= a_d;
    b_q    <= b_d;
    u_q    <= u_d;
    u2_q   <= u2_d;
    u3_q   <= u3_d;
    sm0_q  <= sm0_d;
    sm1_q  <= sm1_d;
    bas_q  <= bas_d;
    tk_q   <= tk_d;
    ms_q   <= ms_d;
    p1_q   <= p1_d;
    acc_q  <= acc_d;
    val_q  <= val_d;
    tim_q  <= tim_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  assign in_stall_o     = (state_q != chs_pkg::S_IDLE);
  assign out_valid_o    = (state_q == chs_pkg::S_OUT);
  assign result_value_o = val_q;
  assign result_time_o  = tim_q;
  assign status_o       = stat_q;
  assign last_sample_o  = last_q;
  assign cfg_ready_o    = 1'b1;

endmodule

// File: rtl/chs_checker.sv
// chs_checker: port-level checks on the cubic hermite spline table top level
// depends on chs_pkg, bound to cubic_hermite_spline_table_top
module chs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [31:0] result_value_o,
  input logic [1:0]  status_o,
  input logic        last_sample_o
);

  // one request at a time: a pending result beat holds off new requests
  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while a result beat is pending");

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request channel not stalled after a beat");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_value_o) &&
                                      $stable(status_o)))
    else $error("stalled result beat changed");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_sample_o) |->
      (status_o == chs_pkg::ST_OK || status_o == chs_pkg::ST_SAT))
    else $error("final sample with bad status");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == chs_pkg::ST_FULL) |->
      (result_value_o == 32'sd0 && !last_sample_o))
    else $error("table full beat carries data");

endmodule

bind cubic_hermite_spline_table_top chs_checker u_chs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .status_o       (status_o),
  .last_sample_o  (last_sample_o)
);
